// File: hdl/bca_pkg.sv
`timescale 1ns / 1ps

package bca_pkg;

   // default pool size
   localparam int NUM_BLOCKS_DEFAULT = 128;

   // field widths of the request and response words
   localparam int REQ_TYPE_W    = 1;
   localparam int BLOCK_COUNT_W = 8;
   localparam int START_BLOCK_W = 7;
   localparam int STATUS_W      = 2;
   localparam int FIRST_BLOCK_W = 7;
   localparam int FREE_BLOCKS_W = 8;

   // request operations
   localparam logic [REQ_TYPE_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] OP_FREE  = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd3;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]    req_type;
      logic [BLOCK_COUNT_W-1:0] block_count;
      logic [START_BLOCK_W-1:0] start_block;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [FIRST_BLOCK_W-1:0] first_block;
      logic [FREE_BLOCKS_W-1:0] free_blocks;
   } rsp_word_type;

endpackage

// File: hdl/block_chain_allocator_top.sv
`timescale 1ns / 1ps

// FAT-style block allocator over NUM_BLOCKS blocks. Each block has one word in
// a single-port-read table holding its used flag and next-block link. After
// reset a clearing pass empties the table; no request is taken until it ends.
// One request is handled at a time. Allocate scans the table one block per
// cycle through the read port and stops at the last block it needs. Free walks
// the chain one block per cycle. Requests rejected on their fields (zero count,
// too many blocks, start out of range) answer straight from the decode; a free
// of an unused start block answers after its first table read. The response
// sits in an output register, so the block accepts the next request while it
// waits to be taken.
module block_chain_allocator_top #(
   parameter int NUM_BLOCKS = bca_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bca_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bca_pkg::rsp_word_type rsp_data
);

   import bca_pkg::*;

   logic         eng_valid;
   logic         eng_ready;
   rsp_word_type eng_data;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;

   bca_engine #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (eng_valid),
      .res_ready (eng_ready),
      .res_data  (eng_data)
   );

   // output word register
   assign eng_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_valid && eng_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // an accepted word keeps the engine busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("engine took a second word straight after a first");

   // a pending engine result means no new word is taken
   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      eng_valid |-> !req_ready)
      else $error("word accepted while a result is pending");

   // only a successful allocate names a first block
   a_first_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |-> (rsp_data.first_block == '0))
      else $error("first block set on a failed request");
`endif

endmodule

// File: hdl/bca_ram.sv
`timescale 1ns / 1ps

module bca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read (old data on a same-address collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/bca_engine.sv
`timescale 1ns / 1ps

module bca_engine #(
   parameter int NUM_BLOCKS = bca_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bca_pkg::req_word_type req_data,
   output logic                  res_valid,
   input  logic                  res_ready,
   output bca_pkg::rsp_word_type res_data
);

   import bca_pkg::*;

   localparam int IDX_W  = $clog2(NUM_BLOCKS);
   localparam int LINK_W = IDX_W + 1;
   localparam int WORD_W = LINK_W + 1;
   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
   localparam int CMP_W  = (CNT_W > BLOCK_COUNT_W) ? CNT_W : BLOCK_COUNT_W;
   localparam int SW     = (IDX_W > START_BLOCK_W) ? IDX_W : START_BLOCK_W;

   // entry layout: used flag, end-of-chain flag, next block index
   localparam logic [LINK_W-1:0] END_LINK  = {1'b1, {IDX_W{1'b0}}};
   localparam logic [WORD_W-1:0] FREE_WORD = {1'b0, END_LINK};
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_BLOCKS - 1);
   localparam logic [CNT_W-1:0]  NUM_CNT   = CNT_W'(NUM_BLOCKS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC,
      ST_ALLOC_END,
      ST_FREE_WALK,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                data_vld_ff, data_vld_in;
   logic [IDX_W-1:0]    data_addr_ff, data_addr_in;
   logic [CMP_W-1:0]    count_ff, count_in;
   logic [CMP_W-1:0]    got_ff, got_in;
   logic [IDX_W-1:0]    prev_ff, prev_in;
   logic [IDX_W-1:0]    first_ff, first_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [CNT_W-1:0]    steps_ff, steps_in;
   logic                head_ff, head_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0]    free_cnt_ff, free_cnt_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [WORD_W-1:0]   wr_data;
   logic [IDX_W-1:0]    rd_addr;
   logic [WORD_W-1:0]   rd_word;

   logic                rd_used;
   logic                rd_end;
   logic [IDX_W-1:0]    rd_idx;
   logic                rd_idx_out;
   logic [SW-1:0]       start_w;
   logic [IDX_W-1:0]    start_idx;
   logic                start_ok;
   logic [CMP_W-1:0]    want;
   logic [CMP_W-1:0]    avail;
   logic [CMP_W-1:0]    got_next;
   logic [CNT_W-1:0]    steps_next;

   // block table: one word per block
   bca_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // fields of the word read last cycle
   assign rd_used    = rd_word[WORD_W-1];
   assign rd_end     = rd_word[LINK_W-1];
   assign rd_idx     = rd_word[IDX_W-1:0];
   assign rd_idx_out = (CNT_W'(rd_idx) >= NUM_CNT);

   // request decode
   assign start_w    = SW'(req_data.start_block);
   assign start_idx  = start_w[IDX_W-1:0];
   assign start_ok   = (32'(req_data.start_block) < 32'(NUM_BLOCKS));
   assign want       = CMP_W'(req_data.block_count);
   assign avail      = CMP_W'(free_cnt_ff);
   assign got_next   = got_ff + 1'b1;
   assign steps_next = steps_ff + 1'b1;

   // sequencer: clearing pass, table scan, chain walk
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      issue_in     = issue_ff;
      data_vld_in  = 1'b0;
      data_addr_in = data_addr_ff;
      count_in     = count_ff;
      got_in       = got_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      head_in      = head_ff;
      status_in    = status_ff;
      free_cnt_in  = free_cnt_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = FREE_WORD;
      rd_addr      = start_idx;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = FREE_WORD;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            rd_addr = start_idx;
            if (req_valid) begin
               first_in = '0;
               if (req_data.req_type == OP_FREE) begin
                  if (start_ok) begin
                     cur_in   = start_idx;
                     steps_in = '0;
                     head_in  = 1'b1;
                     state_in = ST_FREE_WALK;
                  end else begin
                     status_in = STATUS_NOT_USED;
                     state_in  = ST_DONE;
                  end
               end else if (want == '0) begin
                  status_in = STATUS_ZERO;
                  state_in  = ST_DONE;
               end else if (want > avail) begin
                  status_in = STATUS_NO_SPACE;
                  state_in  = ST_DONE;
               end else begin
                  count_in = want;
                  got_in   = '0;
                  issue_in = '0;
                  state_in = ST_ALLOC;
               end
            end
         end

         ST_ALLOC: begin
            // stream reads through the table, one block a cycle
            rd_addr = issue_ff[IDX_W-1:0];
            if (issue_ff < NUM_CNT) begin
               issue_in     = issue_ff + 1'b1;
               data_vld_in  = 1'b1;
               data_addr_in = issue_ff[IDX_W-1:0];
            end
            // claim a free block; link the previous one to it
            if (data_vld_ff && !rd_used) begin
               if (got_ff == '0) begin
                  first_in = data_addr_ff;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = prev_ff;
                  wr_data = {1'b1, 1'b0, data_addr_ff};
               end
               prev_in = data_addr_ff;
               got_in  = got_next;
               if (got_next == count_ff) begin
                  data_vld_in = 1'b0;
                  state_in    = ST_ALLOC_END;
               end
            end
         end

         ST_ALLOC_END: begin
            // close the chain on its last block
            wr_en       = 1'b1;
            wr_addr     = prev_ff;
            wr_data     = {1'b1, END_LINK};
            free_cnt_in = free_cnt_ff - CNT_W'(count_ff);
            status_in   = STATUS_OK;
            state_in    = ST_DONE;
         end

         ST_FREE_WALK: begin
            rd_addr = rd_idx;
            if (head_ff && !rd_used) begin
               status_in = STATUS_NOT_USED;
               state_in  = ST_DONE;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = cur_ff;
               wr_data  = FREE_WORD;
               head_in  = 1'b0;
               steps_in = steps_next;
               cur_in   = rd_idx;
               if (rd_used) begin
                  free_cnt_in = free_cnt_ff + 1'b1;
               end
               if (rd_end || rd_idx_out || steps_next == NUM_CNT) begin
                  status_in = STATUS_OK;
                  state_in  = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         data_vld_ff <= 1'b0;
         head_ff     <= 1'b0;
         free_cnt_ff <= NUM_CNT;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         data_vld_ff <= data_vld_in;
         head_ff     <= head_in;
         free_cnt_ff <= free_cnt_in;
      end
      issue_ff     <= issue_in;
      data_addr_ff <= data_addr_in;
      count_ff     <= count_in;
      got_ff       <= got_in;
      prev_ff      <= prev_in;
      first_ff     <= first_in;
      cur_ff       <= cur_in;
      steps_ff     <= steps_in;
      status_ff    <= status_in;
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign res_valid            = (state_ff == ST_DONE);
   assign res_data.status      = status_ff;
   assign res_data.first_block = FIRST_BLOCK_W'(first_ff);
   assign res_data.free_blocks = FREE_BLOCKS_W'(free_cnt_ff);

endmodule
